>>> src/qss_pkg.sv
// Shared types and constants for the quicksort sorter.
`default_nettype none

package qss_pkg;

   localparam int DATA_WIDTH        = 32;
   localparam int MAX_ITEMS_DEF     = 64;
   localparam int STACK_SLOTS       = 7;
   localparam int STACK_DEPTH_WIDTH = $clog2(STACK_SLOTS + 1);

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] value;
      logic                         last;
   } req_word_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] sorted_value;
      logic                         final_res;
      logic                         overflow;
   } rsp_word_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INIT,
      S_POP,
      S_PART,
      S_PIVOT,
      S_SCAN_B,
      S_CMP_B,
      S_SCAN_E,
      S_CMP_E,
      S_SWAP_B,
      S_SWAP_E,
      S_SPLIT,
      S_EMIT_RD,
      S_EMIT_LD,
      S_EMIT_OUT
   } state_type;

endpackage

`default_nettype wire

>>> src/qss_ram.sv
// Generic RAM: one write port, two registered read ports.
`default_nettype none

module qss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
   output logic      [WIDTH-1:0]         rdata_a,
   input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic      [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
   end

endmodule

`default_nettype wire

>>> src/qss_cmp.sv
// Shared signed compare unit for both partition scans.
`default_nettype none

module qss_cmp #(
   parameter int WIDTH = qss_pkg::DATA_WIDTH
) (
   input  wire logic              side,   // 0: left scan (elem < pivot), 1: right scan
   input  wire logic signed [WIDTH-1:0] elem,
   input  wire logic signed [WIDTH-1:0] pivot,
   output logic                   hit
);

   logic signed [WIDTH-1:0] op_l;
   logic signed [WIDTH-1:0] op_r;

   always_comb begin
      op_l = side ? pivot : elem;
      op_r = side ? elem  : pivot;
      hit  = op_l < op_r;
   end

endmodule

`default_nettype wire

>>> src/quicksort_sorter_unit.sv
// Top level: batch loader, quicksort sequencer and sorted-word emitter.
//
//   channel  dir  word type      handshake
//   req      in   req_word_type  req_valid / req_stall
//   rsp      out  rsp_word_type  rsp_valid / rsp_stall
//
// Loading accepts one word per cycle; req_stall is high from the last word until
// the final sorted word is taken. Sorting runs on one compare unit and one RAM:
// a scan starts in S_SCAN_B/E, then steps one element per cycle in S_CMP_B/E;
// a swap writes in S_SWAP_B, S_SWAP_E; a pop is S_POP, then the S_PART range check.
// Emission runs S_EMIT_RD (RAM read), S_EMIT_LD and S_EMIT_OUT, held on rsp_stall.
// Reset clears control state only; the element RAM needs no clearing pass.
`default_nettype none

module quicksort_sorter_unit #(
   parameter int MAX_ITEMS = qss_pkg::MAX_ITEMS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire qss_pkg::req_word_type req_word,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output qss_pkg::rsp_word_type     rsp_word
);

   localparam int DW    = qss_pkg::DATA_WIDTH;
   localparam int IW    = $clog2(MAX_ITEMS);
   localparam int CW    = $clog2(MAX_ITEMS + 1);
   localparam int PW    = IW + 2;
   localparam int SW    = qss_pkg::STACK_DEPTH_WIDTH;
   localparam int SLOTS = qss_pkg::STACK_SLOTS;

   localparam logic signed [PW-1:0] ONE  = PW'(1);
   localparam logic signed [PW-1:0] TWO  = PW'(2);
   localparam logic signed [PW-1:0] ZERO = PW'(0);

   qss_pkg::state_type state_ff, state_in;

   logic [CW-1:0]   count_ff, count_in;
   logic            dropped_ff, dropped_in;
   logic [SW-1:0]   depth_ff, depth_in;
   logic [IW-1:0]   stack_lo_ff [SLOTS];
   logic [IW-1:0]   stack_lo_in [SLOTS];
   logic [IW-1:0]   stack_hi_ff [SLOTS];
   logic [IW-1:0]   stack_hi_in [SLOTS];
   logic signed [PW-1:0] lo_ff, lo_in, hi_ff, hi_in, b_ff, b_in, e_ff, e_in;
   logic signed [DW-1:0] pivot_ff, pivot_in, val_b_ff, val_b_in, val_e_ff, val_e_in;
   logic [CW-1:0]   k_ff, k_in;
   logic            rsp_valid_ff, rsp_valid_in;
   qss_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic            ram_we;
   logic [IW-1:0]   ram_waddr, ram_ra, ram_rb;
   logic [DW-1:0]   ram_wdata, ram_qa, ram_qb;

   logic                 cmp_side;
   logic signed [DW-1:0] cmp_elem;
   logic                 cmp_hit;

   logic                 accept, full, more_b, more_e, rsp_take, last_k;
   logic signed [PW-1:0] size, lsize, rsize, b_inc, e_dec, pivot_idx;
   logic [SW-1:0]        top_slot;

   qss_ram #(
      .WIDTH(DW),
      .DEPTH(MAX_ITEMS)
   ) u_ram (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (ram_waddr),
      .wdata   (ram_wdata),
      .raddr_a (ram_ra),
      .rdata_a (ram_qa),
      .raddr_b (ram_rb),
      .rdata_b (ram_qb)
   );

   qss_cmp #(
      .WIDTH(DW)
   ) u_cmp (
      .side  (cmp_side),
      .elem  (cmp_elem),
      .pivot (pivot_ff),
      .hit   (cmp_hit)
   );

   assign req_stall = (state_ff != qss_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      accept    = req_valid && !req_stall;
      full      = (count_ff == CW'(MAX_ITEMS));
      size      = hi_ff - lo_ff + ONE;
      lsize     = e_ff - lo_ff + ONE;
      rsize     = hi_ff - b_ff + ONE;
      b_inc     = b_ff + ONE;
      e_dec     = e_ff - ONE;
      pivot_idx = lo_ff + (size >>> 1);
      top_slot  = depth_ff - SW'(1);
      cmp_side  = (state_ff == qss_pkg::S_CMP_E);
      cmp_elem  = cmp_side ? $signed(ram_qb) : $signed(ram_qa);
      more_b    = (b_ff < hi_ff) && cmp_hit;
      more_e    = (e_ff > lo_ff) && cmp_hit;
      rsp_take  = rsp_valid_ff && !rsp_stall;
      last_k    = ((k_ff + CW'(1)) == count_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         qss_pkg::S_IDLE: begin
            if (accept && req_word.last) state_in = qss_pkg::S_INIT;
         end
         qss_pkg::S_INIT: begin
            state_in = (count_ff >= CW'(2)) ? qss_pkg::S_PART : qss_pkg::S_EMIT_RD;
         end
         qss_pkg::S_POP: begin
            state_in = (depth_ff == '0) ? qss_pkg::S_EMIT_RD : qss_pkg::S_PART;
         end
         qss_pkg::S_PART: begin
            state_in = (size < TWO) ? qss_pkg::S_POP : qss_pkg::S_PIVOT;
         end
         qss_pkg::S_PIVOT:  state_in = qss_pkg::S_SCAN_B;
         qss_pkg::S_SCAN_B: state_in = qss_pkg::S_CMP_B;
         qss_pkg::S_CMP_B: begin
            state_in = more_b ? qss_pkg::S_CMP_B : qss_pkg::S_SCAN_E;
         end
         qss_pkg::S_SCAN_E: state_in = qss_pkg::S_CMP_E;
         qss_pkg::S_CMP_E: begin
            if (more_e) state_in = qss_pkg::S_CMP_E;
            else state_in = (b_ff <= e_ff) ? qss_pkg::S_SWAP_B : qss_pkg::S_SPLIT;
         end
         qss_pkg::S_SWAP_B: state_in = qss_pkg::S_SWAP_E;
         qss_pkg::S_SWAP_E: begin
            state_in = (b_inc <= e_dec) ? qss_pkg::S_SCAN_B : qss_pkg::S_SPLIT;
         end
         qss_pkg::S_SPLIT:   state_in = qss_pkg::S_PART;
         qss_pkg::S_EMIT_RD: state_in = qss_pkg::S_EMIT_LD;
         qss_pkg::S_EMIT_LD: state_in = qss_pkg::S_EMIT_OUT;
         qss_pkg::S_EMIT_OUT: begin
            if (rsp_take) begin
               state_in = rsp_word_ff.final_res ? qss_pkg::S_IDLE : qss_pkg::S_EMIT_RD;
            end
         end
         default: state_in = qss_pkg::S_IDLE;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      depth_in     = depth_ff;
      stack_lo_in  = stack_lo_ff;
      stack_hi_in  = stack_hi_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      b_in         = b_ff;
      e_in         = e_ff;
      pivot_in     = pivot_ff;
      val_b_in     = val_b_ff;
      val_e_in     = val_e_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      ram_we       = 1'b0;
      ram_waddr    = count_ff[IW-1:0];
      ram_wdata    = req_word.value;
      ram_ra       = b_ff[IW-1:0];
      ram_rb       = e_ff[IW-1:0];
      case (state_ff)
         qss_pkg::S_IDLE: begin
            if (accept) begin
               if (!full) begin
                  ram_we   = 1'b1;
                  count_in = count_ff + CW'(1);
               end else begin
                  dropped_in = 1'b1;
               end
            end
         end
         qss_pkg::S_INIT: begin
            lo_in    = ZERO;
            hi_in    = $signed(PW'(count_ff)) - ONE;
            depth_in = '0;
            k_in     = '0;
         end
         qss_pkg::S_POP: begin
            if (depth_ff != '0) begin
               lo_in    = $signed(PW'(stack_lo_ff[top_slot]));
               hi_in    = $signed(PW'(stack_hi_ff[top_slot]));
               depth_in = top_slot;
            end
         end
         qss_pkg::S_PART: begin
            ram_ra = pivot_idx[IW-1:0];
         end
         qss_pkg::S_PIVOT: begin
            pivot_in = ram_qa;
            b_in     = lo_ff;
            e_in     = hi_ff;
         end
         qss_pkg::S_SCAN_B: begin
            ram_ra = b_ff[IW-1:0];
         end
         qss_pkg::S_CMP_B: begin
            // read ahead so a continuing scan advances one step per cycle
            ram_ra = b_inc[IW-1:0];
            if (more_b) b_in = b_inc;
            else val_b_in = ram_qa;
         end
         qss_pkg::S_SCAN_E: begin
            ram_rb = e_ff[IW-1:0];
         end
         qss_pkg::S_CMP_E: begin
            ram_rb = e_dec[IW-1:0];
            if (more_e) e_in = e_dec;
            else val_e_in = ram_qb;
         end
         qss_pkg::S_SWAP_B: begin
            ram_we    = 1'b1;
            ram_waddr = b_ff[IW-1:0];
            ram_wdata = val_e_ff;
         end
         qss_pkg::S_SWAP_E: begin
            ram_we    = 1'b1;
            ram_waddr = e_ff[IW-1:0];
            ram_wdata = val_b_ff;
            b_in      = b_inc;
            e_in      = e_dec;
         end
         qss_pkg::S_SPLIT: begin
            // push the larger part (if two or more elements and a slot is free), keep working on the smaller one
            if (lsize >= rsize) begin
               if (lsize >= TWO && depth_ff != SW'(SLOTS)) begin
                  stack_lo_in[depth_ff] = lo_ff[IW-1:0];
                  stack_hi_in[depth_ff] = e_ff[IW-1:0];
                  depth_in              = depth_ff + SW'(1);
               end
               lo_in = b_ff;
            end else begin
               if (rsize >= TWO && depth_ff != SW'(SLOTS)) begin
                  stack_lo_in[depth_ff] = b_ff[IW-1:0];
                  stack_hi_in[depth_ff] = hi_ff[IW-1:0];
                  depth_in              = depth_ff + SW'(1);
               end
               hi_in = e_ff;
            end
         end
         qss_pkg::S_EMIT_RD: begin
            ram_ra = k_ff[IW-1:0];
         end
         qss_pkg::S_EMIT_LD: begin
            rsp_valid_in             = 1'b1;
            rsp_word_in.sorted_value = ram_qa;
            rsp_word_in.final_res    = last_k;
            rsp_word_in.overflow     = dropped_ff;
         end
         qss_pkg::S_EMIT_OUT: begin
            if (rsp_take) begin
               rsp_valid_in = 1'b0;
               if (rsp_word_ff.final_res) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  depth_in   = '0;
               end else begin
                  k_in = k_ff + CW'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qss_pkg::S_IDLE;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stack_lo_ff <= stack_lo_in;
      stack_hi_ff <= stack_hi_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      b_ff        <= b_in;
      e_ff        <= e_in;
      pivot_ff    <= pivot_in;
      val_b_ff    <= val_b_in;
      val_e_ff    <= val_e_in;
      k_ff        <= k_in;
      rsp_word_ff <= rsp_word_in;
   end

   a_rsp_only_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == qss_pkg::S_EMIT_OUT)
      else $error("rsp word valid outside emit state");

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff < SW'(SLOTS))
      else $error("range stack reached its last slot");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ITEMS))
      else $error("element count past capacity");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == qss_pkg::S_CMP_B |-> (b_ff >= lo_ff && b_ff <= hi_ff))
      else $error("left scan left its range");

   a_batch_done: assert property (@(posedge clock) disable iff (reset)
      rsp_take && rsp_word_ff.final_res |=>
         state_ff == qss_pkg::S_IDLE && count_ff == '0 && !dropped_ff)
      else $error("batch state not cleared after final word");

endmodule

`default_nettype wire
